// ----- hdl/kmtf_pkg.sv -----
`timescale 1ns / 1ps
package kmtf_pkg;

    // list geometry
    localparam int LIST_SIZE = 256;
    localparam int LIST_W    = $clog2(LIST_SIZE);
    localparam int GRP_SIZE  = 16;
    localparam int GRP_W     = $clog2(GRP_SIZE);
    localparam int N_GRP     = LIST_SIZE / GRP_SIZE;
    localparam int NG_W      = $clog2(N_GRP);

    // key store
    localparam int KEY_LENGTH = 95;
    localparam int KEY_AW     = $clog2(KEY_LENGTH);
    localparam int KEY_BASE   = 32;
    localparam int POS_W      = 7;

    // code word
    localparam int                CODE_W         = 9;
    localparam int                LEN_W          = 4;
    localparam logic [LIST_W-1:0] SHORT_MAX      = LIST_W'(8'h0F);
    localparam logic [CODE_W-1:0] SHORT_FLAG     = CODE_W'(16);
    localparam logic [LEN_W-1:0]  CODE_LEN_SHORT = LEN_W'(5);
    localparam logic [LEN_W-1:0]  CODE_LEN_LONG  = LEN_W'(9);
    localparam logic [LEN_W-1:0]  CODE_LEN_NONE  = LEN_W'(0);

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_RESTART = 2'd1,
        CMD_ENCODE  = 2'd2,
        CMD_DECODE  = 2'd3
    } t_cmd;

    // control broadcast to every list cell
    typedef struct packed {
        logic              init;
        logic              wr_en;
        logic [LIST_W-1:0] wr_pos;
        logic [LIST_W-1:0] wr_data;
        logic              cmp_en;
        logic              dec;
        logic [LIST_W-1:0] probe;
        logic              mv_en;
        logic [LIST_W-1:0] mv_pos;
    } t_cell_ctl;

    // one group's reduced hit result
    typedef struct packed {
        logic              any;
        logic [GRP_W-1:0]  low;
        logic [LIST_W-1:0] sel;
    } t_grp_res;

endpackage

// ----- hdl/kmtf_ram.sv -----
`timescale 1ns / 1ps
module kmtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 95,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/kmtf_cell.sv -----
`timescale 1ns / 1ps
module kmtf_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [kmtf_pkg::LIST_W-1:0] i_idx,
    input  kmtf_pkg::t_cell_ctl         i_ctl,
    input  logic [kmtf_pkg::LIST_W-1:0] i_prev,
    output logic [kmtf_pkg::LIST_W-1:0] o_sym,
    output logic                        o_hit
);
    import kmtf_pkg::*;

    logic [LIST_W-1:0] r_sym;
    logic [LIST_W-1:0] n_sym;
    logic              r_hit;
    logic              n_hit;

    always_comb begin
        n_sym = r_sym;
        if (i_ctl.init) begin
            n_sym = i_idx;
        end else if (i_ctl.wr_en && (i_ctl.wr_pos == i_idx)) begin
            n_sym = i_ctl.wr_data;
        end else if (i_ctl.mv_en && (i_idx <= i_ctl.mv_pos)) begin
            n_sym = i_prev;
        end
    end

    // decode matches on position, encode on content
    always_comb begin
        n_hit = r_hit;
        if (i_ctl.cmp_en) begin
            n_hit = i_ctl.dec ? (i_idx == i_ctl.probe) : (r_sym == i_ctl.probe);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym <= i_idx;
            r_hit <= 1'b0;
        end else begin
            r_sym <= n_sym;
            r_hit <= n_hit;
        end
    end

    assign o_sym = r_sym;
    assign o_hit = r_hit;

endmodule

// ----- hdl/kmtf_group.sv -----
`timescale 1ns / 1ps
module kmtf_group (
    input  logic                                                   i_clk,
    input  logic                                                   i_rst_n,
    input  logic [kmtf_pkg::GRP_SIZE-1:0]                          i_hit,
    input  logic [kmtf_pkg::GRP_SIZE-1:0][kmtf_pkg::LIST_W-1:0]    i_sym,
    output kmtf_pkg::t_grp_res                                     o_res
);
    import kmtf_pkg::*;

    t_grp_res r_res;
    t_grp_res n_res;

    // lowest hit position, and the OR of all hit symbols
    always_comb begin
        n_res = '0;
        for (int k = GRP_SIZE - 1; k >= 0; k--) begin
            if (i_hit[k]) begin
                n_res.any = 1'b1;
                n_res.low = GRP_W'(k);
            end
        end
        for (int k = 0; k < GRP_SIZE; k++) begin
            n_res.sel = n_res.sel | (i_sym[k] & {LIST_W{i_hit[k]}});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= '0;
        end else begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

// ----- hdl/keyed_move_to_front_coder.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// request   in         i_valid / o_stall      i_command, i_key_position, i_value
// result    out        o_valid / i_stall      o_result_value, o_code_word,
//                                             o_code_length, o_miss
//
// Encode and decode run as a sequence of steps: cells compare, 16 group encoders
// reduce, the group results combine, then the cells up to the hit position (the whole row on a miss) shift at once.
// Key load writes the key store RAM directly; restart reads one key byte per cycle out
// of the key store RAM's single read port.
// Reset (synchronous, active low) sets the list to identity and the key store
// to its default bytes through per-entry valid bits.
// A stalled result holds the final shift step until the output register frees.
module keyed_move_to_front_coder
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_command,
    input  logic [kmtf_pkg::POS_W-1:0]  i_key_position,
    input  logic [kmtf_pkg::LIST_W-1:0] i_value,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [kmtf_pkg::LIST_W-1:0] o_result_value,
    output logic [kmtf_pkg::CODE_W-1:0] o_code_word,
    output logic [kmtf_pkg::LEN_W-1:0]  o_code_length,
    output logic                        o_miss
);
    import kmtf_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CMP   = 8'b0000_0010,
        S_GRP   = 8'b0000_0100,
        S_IDX   = 8'b0000_1000,
        S_MOVE  = 8'b0001_0000,
        S_INIT  = 8'b0010_0000,
        S_FILL  = 8'b0100_0000,
        S_DRAIN = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic accept;
    logic out_free;
    logic do_move;
    t_cmd cmd;

    // request capture
    logic              r_dec;
    logic [LIST_W-1:0] r_value;

    // combined search result
    logic              r_found;
    logic [LIST_W-1:0] r_idx;
    logic [LIST_W-1:0] r_sym;
    logic              n_found;
    logic [LIST_W-1:0] n_idx;
    logic [LIST_W-1:0] n_sym;

    // restart sweep
    logic [KEY_AW-1:0] r_cnt;
    logic              r_wr_vld;
    logic [KEY_AW-1:0] r_wr_pos;
    logic              r_wr_kv;
    logic [KEY_LENGTH-1:0] r_key_vld;

    // key store RAM
    logic              key_we;
    logic [KEY_AW-1:0] key_waddr;
    logic [LIST_W-1:0] key_rdata;

    // output register
    logic              r_out_vld;
    logic [LIST_W-1:0] r_res;
    logic [CODE_W-1:0] r_code;
    logic [LEN_W-1:0]  r_len;
    logic              r_miss;

    // cell row
    t_cell_ctl                          cell_ctl;
    logic [LIST_SIZE-1:0][LIST_W-1:0]   w_sym;
    logic [LIST_SIZE-1:0]               w_hit;
    logic [LIST_W-1:0]                  front;
    t_grp_res                           grp_res [N_GRP];

    logic [LIST_W-1:0] idx_out;

    assign cmd      = t_cmd'(i_command);
    assign accept   = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign out_free = !r_out_vld || !i_stall;
    assign do_move  = (r_state == S_MOVE) && out_free;

    // ---------------------------------------------------------------- key store
    assign key_waddr = KEY_AW'(i_key_position);
    assign key_we    = accept && (cmd == CMD_LOAD)
                       && ({1'b0, i_key_position} < (POS_W + 1)'(KEY_LENGTH));

    kmtf_ram #(
        .WIDTH(LIST_W),
        .DEPTH(KEY_LENGTH)
    ) u_key_ram (
        .i_clk  (i_clk),
        .i_we   (key_we),
        .i_waddr(key_waddr),
        .i_wdata(i_value),
        .i_raddr(r_cnt),
        .o_rdata(key_rdata)
    );

    // -------------------------------------------------------------- sequencing
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (cmd) inside
                        CMD_LOAD:              n_state = S_IDLE;
                        CMD_RESTART:           n_state = S_INIT;
                        CMD_ENCODE, CMD_DECODE: n_state = S_CMP;
                        default:               n_state = S_IDLE;
                    endcase
                end
            end
            S_CMP:   n_state = S_GRP;
            S_GRP:   n_state = S_IDX;
            S_IDX:   n_state = S_MOVE;
            S_MOVE:  n_state = out_free ? S_IDLE : S_MOVE;
            S_INIT:  n_state = S_FILL;
            S_FILL:  n_state = (r_cnt == KEY_AW'(KEY_LENGTH - 1)) ? S_DRAIN : S_FILL;
            S_DRAIN: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wr_vld  <= 1'b0;
            r_cnt     <= '0;
            r_key_vld <= '0;
        end else begin
            r_state <= n_state;
            if (key_we) begin
                r_key_vld[key_waddr] <= 1'b1;
            end
            if (r_state == S_INIT) begin
                r_cnt    <= '0;
                r_wr_vld <= 1'b0;
            end else if (r_state == S_FILL) begin
                r_cnt    <= r_cnt + 1'b1;
                r_wr_vld <= 1'b1;
            end else begin
                r_wr_vld <= 1'b0;
            end
        end
    end

    // sweep payload: position and valid bit are registered alongside the RAM read data
    always_ff @(posedge i_clk) begin
        if (r_state == S_FILL) begin
            r_wr_pos <= r_cnt;
            r_wr_kv  <= r_key_vld[r_cnt];
        end
        if (accept) begin
            r_dec   <= (cmd == CMD_DECODE);
            r_value <= i_value;
        end
        if (r_state == S_IDX) begin
            r_found <= n_found;
            r_idx   <= n_idx;
            r_sym   <= n_sym;
        end
    end

    // ---------------------------------------------------------------- cell row
    always_comb begin
        cell_ctl         = '0;
        cell_ctl.init    = (r_state == S_INIT);
        cell_ctl.wr_en   = r_wr_vld;
        cell_ctl.wr_pos  = LIST_W'(KEY_BASE) + LIST_W'(r_wr_pos);
        // a never-written key byte reads as its default
        cell_ctl.wr_data = r_wr_kv ? key_rdata : (LIST_W'(KEY_BASE) + LIST_W'(r_wr_pos));
        cell_ctl.cmp_en  = (r_state == S_CMP);
        cell_ctl.dec     = r_dec;
        cell_ctl.probe   = r_value;
        cell_ctl.mv_en   = do_move;
        // missing byte: the whole row shifts and the last entry drops out
        cell_ctl.mv_pos  = r_found ? r_idx : LIST_W'(LIST_SIZE - 1);
    end

    assign front = r_dec ? r_sym : r_value;

    for (genvar g = 0; g < LIST_SIZE; g++) begin : g_cell
        if (g == 0) begin : g_head
            kmtf_cell u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_idx  (LIST_W'(g)),
                .i_ctl  (cell_ctl),
                .i_prev (front),
                .o_sym  (w_sym[g]),
                .o_hit  (w_hit[g])
            );
        end else begin : g_body
            kmtf_cell u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_idx  (LIST_W'(g)),
                .i_ctl  (cell_ctl),
                .i_prev (w_sym[g-1]),
                .o_sym  (w_sym[g]),
                .o_hit  (w_hit[g])
            );
        end
    end

    for (genvar g = 0; g < N_GRP; g++) begin : g_grp
        kmtf_group u_grp (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_hit  (w_hit[g*GRP_SIZE +: GRP_SIZE]),
            .i_sym  (w_sym[g*GRP_SIZE +: GRP_SIZE]),
            .o_res  (grp_res[g])
        );
    end

    // lowest group with a hit gives the list position
    always_comb begin
        n_found = 1'b0;
        n_idx   = '0;
        n_sym   = '0;
        for (int g = N_GRP - 1; g >= 0; g--) begin
            if (grp_res[g].any) begin
                n_found = 1'b1;
                n_idx   = {NG_W'(g), grp_res[g].low};
                n_sym   = grp_res[g].sel;
            end
        end
    end

    // ---------------------------------------------------------------- result
    assign idx_out = r_found ? r_idx : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (do_move) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_move) begin
            if (r_dec) begin
                r_res  <= r_sym;
                r_code <= '0;
                r_len  <= CODE_LEN_NONE;
                r_miss <= 1'b0;
            end else begin
                r_res  <= idx_out;
                r_miss <= !r_found;
                if (idx_out <= SHORT_MAX) begin
                    r_code <= SHORT_FLAG + CODE_W'(idx_out);
                    r_len  <= CODE_LEN_SHORT;
                end else begin
                    r_code <= CODE_W'(idx_out);
                    r_len  <= CODE_LEN_LONG;
                end
            end
        end
    end

    assign o_valid        = r_out_vld;
    assign o_result_value = r_res;
    assign o_code_word    = r_code;
    assign o_code_length  = r_len;
    assign o_miss         = r_miss;

`ifndef SYNTHESIS
    a_result_from_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_MOVE))
        else $error("result raised outside the shift step");

    a_miss_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_miss) |-> (o_result_value == '0 && o_code_length == CODE_LEN_SHORT))
        else $error("miss without zero index and short code");

    a_short_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_code_length == CODE_LEN_SHORT) |-> (o_code_word[CODE_W-1:4] == 5'b00001))
        else $error("short code word without its flag");

    a_decode_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDX) && r_dec) |=> r_found)
        else $error("decode position not located in the cell row");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> ({1'b0, r_cnt} < (KEY_AW + 1)'(KEY_LENGTH)))
        else $error("restart sweep past the key store");
`endif

endmodule

// ----- tb/tb_keyed_move_to_front_coder.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the keyed move-to-front coder.
// Requests go in on valid/stall, results come back on valid/stall; a scoreboard
// object keeps its own copy of the symbol list and key store and predicts
// every encode/decode result in request order.
module tb_keyed_move_to_front_coder;
    import kmtf_pkg::*;

    localparam int N_RANDOM      = 550;          // counted random requests
    localparam int HOLD_AFTER    = 150;          // requests before the long receiver hold
    localparam int HOLD_CYCLES   = 250;
    localparam int DRAIN_AT      = 350;          // sender waits for an empty scoreboard here
    localparam int IDLE_LIMIT    = 4000;         // cycles without any handshake
    localparam int SETTLE_CYCLES = KEY_LENGTH + 16;

    // Predictor plus in-order store of expected results.
    class mtf_scoreboard;
        logic [LIST_W-1:0] symbols   [LIST_SIZE];
        logic [LIST_W-1:0] key_bytes [KEY_LENGTH];
        logic [LIST_W-1:0] exp_value [$];
        logic [CODE_W-1:0] exp_code  [$];
        logic [LEN_W-1:0]  exp_len   [$];
        logic              exp_miss  [$];
        int                errors;

        function new();
            errors = 0;
            for (int i = 0; i < KEY_LENGTH; i++) key_bytes[i] = LIST_W'(i + KEY_BASE);
            for (int i = 0; i < LIST_SIZE; i++) symbols[i] = LIST_W'(i);
        endfunction

        function void move_to_front(int pos, logic [LIST_W-1:0] sym);
            for (int k = pos; k > 0; k--) symbols[k] = symbols[k-1];
            symbols[0] = sym;
        endfunction

        function void push_expected(logic [LIST_W-1:0] v, logic [CODE_W-1:0] c,
                                    logic [LEN_W-1:0] l, logic m);
            exp_value.push_back(v);
            exp_code.push_back(c);
            exp_len.push_back(l);
            exp_miss.push_back(m);
        endfunction

        // Called for every accepted request.
        function void note_request(t_cmd cmd, logic [POS_W-1:0] pos, logic [LIST_W-1:0] val);
            int                idx;
            bit                found;
            logic [LIST_W-1:0] sym;
            case (cmd)
                CMD_LOAD: begin
                    // out-of-range positions are dropped silently
                    if (pos < KEY_LENGTH) key_bytes[pos] = val;
                end
                CMD_RESTART: begin
                    for (int i = 0; i < LIST_SIZE; i++) symbols[i] = LIST_W'(i);
                    for (int i = 0; i < KEY_LENGTH; i++) symbols[KEY_BASE + i] = key_bytes[i];
                end
                CMD_ENCODE: begin
                    idx   = 0;
                    found = 1'b0;
                    // lowest position wins when the key has duplicates
                    for (int i = 0; i < LIST_SIZE; i++) begin
                        if (!found && symbols[i] == val) begin
                            idx   = i;
                            found = 1'b1;
                        end
                    end
                    // a miss pushes the whole list back, dropping the last entry
                    move_to_front(found ? idx : LIST_SIZE - 1, val);
                    if (idx <= SHORT_MAX)
                        push_expected(LIST_W'(idx), SHORT_FLAG + CODE_W'(idx), CODE_LEN_SHORT,
                                      !found);
                    else
                        push_expected(LIST_W'(idx), CODE_W'(idx), CODE_LEN_LONG, !found);
                end
                CMD_DECODE: begin
                    sym = symbols[val];
                    move_to_front(val, sym);
                    push_expected(sym, '0, CODE_LEN_NONE, 1'b0);
                end
            endcase
        endfunction

        // Called for every accepted result.
        function void check_result(logic [LIST_W-1:0] v, logic [CODE_W-1:0] c,
                                   logic [LEN_W-1:0] l, logic m);
            logic [LIST_W-1:0] wv;
            logic [CODE_W-1:0] wc;
            logic [LEN_W-1:0]  wl;
            logic              wm;
            if (exp_value.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected: value %0d code %0d len %0d miss %0d",
                         $time, v, c, l, m);
                return;
            end
            wv = exp_value.pop_front();
            wc = exp_code.pop_front();
            wl = exp_len.pop_front();
            wm = exp_miss.pop_front();
            if (v !== wv) begin
                errors++;
                $display("%0t: result_value expected %0d actual %0d", $time, wv, v);
            end
            if (c !== wc) begin
                errors++;
                $display("%0t: code_word expected %0d actual %0d", $time, wc, c);
            end
            if (l !== wl) begin
                errors++;
                $display("%0t: code_length expected %0d actual %0d", $time, wl, l);
            end
            if (m !== wm) begin
                errors++;
                $display("%0t: miss expected %0d actual %0d", $time, wm, m);
            end
        endfunction

        function int pending();
            return exp_value.size();
        endfunction
    endclass

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_valid        = 1'b0;
    logic [1:0]          i_command      = '0;
    logic [POS_W-1:0]    i_key_position = '0;
    logic [LIST_W-1:0]   i_value        = '0;
    logic                i_stall        = 1'b0;
    logic                o_stall;
    logic                o_valid;
    logic [LIST_W-1:0]   o_result_value;
    logic [CODE_W-1:0]   o_code_word;
    logic [LEN_W-1:0]    o_code_length;
    logic                o_miss;

    mtf_scoreboard sb;
    int            n_accepted = 0;   // requests taken by the block so far
    int            burst_left = 0;   // requests left in the current sender burst
    int            idle_count = 0;

    keyed_move_to_front_coder u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_key_position (i_key_position),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_value (o_result_value),
        .o_code_word    (o_code_word),
        .o_code_length  (o_code_length),
        .o_miss         (o_miss)
    );

    always #1 i_clk = ~i_clk;

    // Sender side drops valid for the given idle gap.
    task automatic idle_sender(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
    endtask

    // One request: bursts of random length, random gaps in between. Valid stays
    // high across back-to-back requests; payload only moves at the falling edge
    // after acceptance.
    task automatic send_request(input t_cmd cmd, input logic [POS_W-1:0] pos,
                                input logic [LIST_W-1:0] val);
        if (burst_left == 0) begin
            if ($urandom_range(0, 9) < 7) idle_sender($urandom_range(1, 8));
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        @(negedge i_clk);
        i_valid        <= 1'b1;
        i_command      <= cmd;
        i_key_position <= pos;
        i_value        <= val;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(cmd, pos, val);
        n_accepted++;
    endtask

    // Random request mix: mostly encode/decode, some key loads and restarts.
    // Encodes lean on a small alphabet so short codes turn up; decodes lean on
    // low indexes for the same reason. Loads with random bytes build duplicate
    // keys, which make later encodes miss.
    task automatic send_random_request(output bit counted);
        int                pick;
        t_cmd              cmd;
        logic [POS_W-1:0]  pos;
        logic [LIST_W-1:0] val;
        pick    = $urandom_range(0, 99);
        pos     = POS_W'($urandom_range(0, KEY_LENGTH - 1));
        val     = LIST_W'($urandom);
        counted = 1'b1;
        if (pick < 8) begin
            cmd = CMD_LOAD;
            if ($urandom_range(0, 4) == 0) begin
                pos     = POS_W'($urandom_range(KEY_LENGTH, (1 << POS_W) - 1));
                counted = 1'b0;
            end
        end else if (pick < 12) begin
            cmd = CMD_RESTART;
        end else if (pick < 58) begin
            cmd = CMD_ENCODE;
            if ($urandom_range(0, 1)) val = LIST_W'($urandom_range(60, 75));
        end else begin
            cmd = CMD_DECODE;
            if ($urandom_range(0, 9) < 6) val = LIST_W'($urandom_range(0, SHORT_MAX));
        end
        send_request(cmd, pos, val);
    endtask

    // Receiver: stall density changes in phases (including stall-free ones),
    // plus one long hold so the block backs up and stalls its request side.
    initial begin
        int  phase_left;
        int  stall_pct;
        bit  held;
        phase_left = 0;
        stall_pct  = 0;
        held       = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && n_accepted >= HOLD_AFTER) begin
                held = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (phase_left == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 60;
                    default: stall_pct = 90;
                endcase
                phase_left = $urandom_range(5, 60);
            end
            phase_left--;
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_result_value, o_code_word, o_code_length, o_miss);
    end

    // Watchdog: too long without any handshake on either side.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int n_random;
        bit counted;
        bit drained;
        sb = new();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: key edges, ignored loads, short/long boundary, misses and
        // duplicate keys, decode at both ends of the list.
        send_request(CMD_ENCODE,  7'd0,   8'd0);     // identity list straight out of reset
        send_request(CMD_LOAD,    7'd0,   8'hFF);    // 32 now absent, 255 twice
        send_request(CMD_LOAD,    7'd94,  8'h00);    // 126 now absent, 0 twice
        send_request(CMD_LOAD,    7'd95,  8'hAA);    // first position past the key
        send_request(CMD_LOAD,    7'd127, 8'h55);    // all position bits set
        send_request(CMD_RESTART, 7'd0,   8'd0);
        send_request(CMD_ENCODE,  7'd0,   8'd15);    // last short index
        send_request(CMD_ENCODE,  7'd0,   8'd16);    // first long index
        send_request(CMD_ENCODE,  7'd0,   8'd255);   // duplicate: lowest position taken
        send_request(CMD_ENCODE,  7'd0,   8'd32);    // not in the list
        send_request(CMD_ENCODE,  7'd0,   8'd126);   // not in the list
        send_request(CMD_ENCODE,  7'd0,   8'd0);
        send_request(CMD_DECODE,  7'd0,   8'd0);
        send_request(CMD_DECODE,  7'd0,   8'd255);
        send_request(CMD_DECODE,  7'd0,   8'd15);
        send_request(CMD_DECODE,  7'd0,   8'd16);
        send_request(CMD_LOAD,    7'd0,   8'd32);    // put the default key back
        send_request(CMD_LOAD,    7'd94,  8'd126);
        send_request(CMD_RESTART, 7'd127, 8'hFF);
        send_request(CMD_ENCODE,  7'd0,   8'd100);
        send_request(CMD_DECODE,  7'd0,   8'd200);

        n_random = 0;
        drained  = 1'b0;
        while (n_random < N_RANDOM) begin
            if (!drained && n_random >= DRAIN_AT) begin
                // sender pauses until every outstanding result is back
                drained = 1'b1;
                idle_sender(1);
                while (sb.pending() != 0) @(posedge i_clk);
            end
            send_random_request(counted);
            if (counted) n_random++;
        end

        idle_sender(1);
        while (sb.pending() != 0) @(posedge i_clk);
        // let a trailing restart finish and catch any stray result
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/kmtf_pkg.sv
hdl/kmtf_ram.sv
hdl/kmtf_cell.sv
hdl/kmtf_group.sv
hdl/keyed_move_to_front_coder.sv
tb/tb_keyed_move_to_front_coder.sv
